@@ rtl/mas_pkg.sv @@
package mas_pkg;

    localparam int MAX_WORDS = 16;
    localparam int WORD_W    = 16;
    localparam int INDEX_W   = 4;
    localparam int IDX_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

endpackage

@@ rtl/mas_in_if.sv @@
interface mas_in_if;

    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [mas_pkg::WORD_W-1:0] a_word;
    logic [mas_pkg::WORD_W-1:0] b_word;
    logic [mas_pkg::WORD_W-1:0] mod_word;
    logic                       last_in;

    modport source (
        output valid, opcode, a_word, b_word, mod_word, last_in,
        input  ready
    );

    modport sink (
        input  valid, opcode, a_word, b_word, mod_word, last_in,
        output ready
    );

endinterface

@@ rtl/mas_out_if.sv @@
interface mas_out_if;

    logic                        valid;
    logic                        ready;
    logic [mas_pkg::WORD_W-1:0]  result_word;
    logic [mas_pkg::INDEX_W-1:0] word_index;
    logic                        last_out;
    logic                        reduced;
    logic                        too_long;

    modport source (
        output valid, result_word, word_index, last_out, reduced, too_long,
        input  ready
    );

    modport sink (
        input  valid, result_word, word_index, last_out, reduced, too_long,
        output ready
    );

endinterface

@@ rtl/modular_add_sub_multiword_unit.sv @@
// Modular add or subtract over operands of up to MAX_WORDS 16-bit words.
// The din channel takes one beat per word position, least significant first,
// carrying the words of a, b and the modulus p. The beat with last_in high
// closes the operand and its opcode selects add (0) or subtract (1).
// Beats past MAX_WORDS are dropped and raise too_long on every result beat.
// Words load at one beat per cycle while din.ready is high. After the closing
// beat, din.ready falls until the last result beat is taken.
// For an operand of n words, one shared 16-bit adder first makes a pass over
// the stored words (S_RD1, S_EX1 per word), forming a +/- b and the compare
// against p. A second pass applies the correction and sends one dout beat
// per word, low first, stepping through S_RD2, S_EX2 and S_OUT per word.
// A stalled dout beat holds its payload and the block simply waits.
// Reset clears the sequencer and word count; the word stores are not cleared
// and are only read at positions written for the current operand.
module modular_add_sub_multiword_unit (
    input  logic             clk,
    input  logic             rst_n,
    mas_in_if.sink           din,
    mas_out_if.source        dout
);

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_RD1  = 6'b000010,
        S_EX1  = 6'b000100,
        S_RD2  = 6'b001000,
        S_EX2  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [mas_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            ovf_reg, ovf_next;
    logic [mas_pkg::CNT_W-1:0]       n_reg, n_next;
    logic [mas_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic                            op_reg, op_next;
    logic                            carry_reg, carry_next;
    logic                            ge_reg, ge_next;
    logic                            red_reg, red_next;
    logic                            flag_reg, flag_next;
    logic [mas_pkg::WORD_W-1:0]      word_reg, word_next;

    logic [mas_pkg::WORD_W-1:0]      a_mem   [mas_pkg::MAX_WORDS];
    logic [mas_pkg::WORD_W-1:0]      b_mem   [mas_pkg::MAX_WORDS];
    logic [mas_pkg::WORD_W-1:0]      p_mem   [mas_pkg::MAX_WORDS];
    logic [mas_pkg::WORD_W-1:0]      res_mem [mas_pkg::MAX_WORDS];
    logic [mas_pkg::WORD_W-1:0]      a_rd_reg, b_rd_reg, p_rd_reg, res_rd_reg;

    logic                            in_acc;
    logic                            out_acc;
    logic                            has_room;
    logic                            load_we;
    logic                            res_we;
    logic [mas_pkg::IDX_W-1:0]       rd_addr;
    logic [mas_pkg::IDX_W-1:0]       wr_addr;
    logic [mas_pkg::CNT_W-1:0]       cnt_inc;
    logic [mas_pkg::CNT_W-1:0]       idx_inc;
    logic                            idx_last;

    logic                            alu_sub;
    logic [mas_pkg::WORD_W-1:0]      alu_x;
    logic [mas_pkg::WORD_W-1:0]      alu_y;
    logic [mas_pkg::WORD_W:0]        alu_sum;
    logic                            word_ge;

    assign in_acc   = din.valid && din.ready;
    assign out_acc  = dout.valid && dout.ready;
    assign has_room = (cnt_reg < mas_pkg::CNT_W'(mas_pkg::MAX_WORDS));
    assign load_we  = in_acc && has_room;
    assign res_we   = (state_reg == S_EX1);
    assign wr_addr  = cnt_reg[mas_pkg::IDX_W-1:0];
    assign rd_addr  = idx_reg[mas_pkg::IDX_W-1:0];
    assign cnt_inc  = cnt_reg + mas_pkg::CNT_W'(1);
    assign idx_inc  = idx_reg + mas_pkg::CNT_W'(1);
    assign idx_last = (idx_inc == n_reg);

    // The first pass forms a +/- b; the second applies p with the opposite sense.
    assign alu_sub = (state_reg == S_EX2) ? (op_reg == mas_pkg::OP_ADD)
                                          : (op_reg == mas_pkg::OP_SUB);
    assign alu_x   = (state_reg == S_EX2) ? res_rd_reg : a_rd_reg;
    assign alu_y   = (state_reg == S_EX2) ? p_rd_reg : b_rd_reg;
    assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                     + {{mas_pkg::WORD_W{1'b0}}, carry_reg};

    assign word_ge = (alu_sum[mas_pkg::WORD_W-1:0] > p_rd_reg)
                     || ((alu_sum[mas_pkg::WORD_W-1:0] == p_rd_reg) && ge_reg);

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            a_mem[wr_addr] <= din.a_word;
            b_mem[wr_addr] <= din.b_word;
            p_mem[wr_addr] <= din.mod_word;
        end
        if (res_we)
        begin
            res_mem[rd_addr] <= alu_sum[mas_pkg::WORD_W-1:0];
        end
        a_rd_reg   <= a_mem[rd_addr];
        b_rd_reg   <= b_mem[rd_addr];
        p_rd_reg   <= p_mem[rd_addr];
        res_rd_reg <= res_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        carry_next = carry_reg;
        ge_next    = ge_reg;
        red_next   = red_reg;
        flag_next  = flag_reg;
        word_next  = word_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (has_room)
                    begin
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (din.last_in)
                    begin
                        n_next     = has_room ? cnt_inc : cnt_reg;
                        flag_next  = ovf_reg || !has_room;
                        op_next    = din.opcode;
                        carry_next = (din.opcode == mas_pkg::OP_SUB);
                        ge_next    = 1'b1;
                        idx_next   = '0;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_RD1;
                    end
                end
            end
            S_RD1:
            begin
                state_next = S_EX1;
            end
            S_EX1:
            begin
                carry_next = alu_sum[mas_pkg::WORD_W];
                ge_next    = word_ge;
                if (idx_last)
                begin
                    if (op_reg == mas_pkg::OP_SUB)
                    begin
                        red_next = !alu_sum[mas_pkg::WORD_W];
                    end
                    else
                    begin
                        red_next = alu_sum[mas_pkg::WORD_W] || word_ge;
                    end
                    carry_next = (op_reg == mas_pkg::OP_ADD);
                    idx_next   = '0;
                    state_next = S_RD2;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_RD1;
                end
            end
            S_RD2:
            begin
                state_next = S_EX2;
            end
            S_EX2:
            begin
                word_next  = red_reg ? alu_sum[mas_pkg::WORD_W-1:0] : res_rd_reg;
                carry_next = alu_sum[mas_pkg::WORD_W];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    if (idx_last)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_RD2;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            n_reg     <= '0;
            idx_reg   <= '0;
            op_reg    <= mas_pkg::OP_ADD;
            carry_reg <= 1'b0;
            ge_reg    <= 1'b1;
            red_reg   <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            op_reg    <= op_next;
            carry_reg <= carry_next;
            ge_reg    <= ge_next;
            red_reg   <= red_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign din.ready        = (state_reg == S_LOAD);
    assign dout.valid       = (state_reg == S_OUT);
    assign dout.result_word = word_reg;
    assign dout.word_index  = mas_pkg::INDEX_W'(idx_reg);
    assign dout.last_out    = idx_last;
    assign dout.reduced     = red_reg;
    assign dout.too_long    = flag_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(din.ready && dout.valid))
        else $error("input accepted while a result beat is pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= mas_pkg::CNT_W'(mas_pkg::MAX_WORDS))
        else $error("word count beyond capacity");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (idx_reg < n_reg))
        else $error("result index beyond operand length");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.ready && dout.last_out) |=> din.ready)
        else $error("block not ready after the final result beat");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready && din.last_in) |=> (cnt_reg == '0 && !ovf_reg))
        else $error("word count not cleared after closing beat");

endmodule

@@ verif/mas_result_checker.sv @@
module mas_result_checker (
    input  logic clk,
    input  logic rst_n,
    mas_in_if    din,
    mas_out_if   dout,
    output int   mismatch_count,
    output int   pending_words
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mas_pkg::WORD_W-1:0]  word;
        logic [mas_pkg::INDEX_W-1:0] index;
        logic                        last;
        logic                        reduced;
        logic                        too_long;
    } result_beat_t;

    logic [mas_pkg::WORD_W-1:0] a_words [mas_pkg::MAX_WORDS];
    logic [mas_pkg::WORD_W-1:0] b_words [mas_pkg::MAX_WORDS];
    logic [mas_pkg::WORD_W-1:0] p_words [mas_pkg::MAX_WORDS];
    int                         stored_words = 0;
    logic                       dropped_word = 1'b0;
    result_beat_t               expected_words [$];

    // The modulus is applied at most once: subtracted after an add that
    // carries out or reaches p, added back after a subtract that borrows.
    function automatic void compute_reduced_words(input logic op);
        logic [mas_pkg::WORD_W-1:0] sum_words [mas_pkg::MAX_WORDS];
        logic [mas_pkg::WORD_W:0]   acc;
        logic                       chain;
        logic                       at_least_p;
        logic                       settled;
        logic                       fix;
        result_beat_t               beat;
        chain = 1'b0;
        for (int k = 0; k < stored_words; k++)
        begin
            if (op == mas_pkg::OP_ADD)
                acc = {1'b0, a_words[k]} + {1'b0, b_words[k]}
                      + {{mas_pkg::WORD_W{1'b0}}, chain};
            else
                acc = {1'b0, a_words[k]} - {1'b0, b_words[k]}
                      - {{mas_pkg::WORD_W{1'b0}}, chain};
            sum_words[k] = acc[mas_pkg::WORD_W-1:0];
            chain = acc[mas_pkg::WORD_W];
        end
        if (op == mas_pkg::OP_ADD)
        begin
            at_least_p = 1'b1;
            settled = 1'b0;
            for (int k = stored_words - 1; k >= 0; k--)
            begin
                if (!settled && sum_words[k] != p_words[k])
                begin
                    at_least_p = (sum_words[k] > p_words[k]);
                    settled = 1'b1;
                end
            end
            fix = chain || at_least_p;
        end
        else
        begin
            fix = chain;
        end
        if (fix)
        begin
            chain = 1'b0;
            for (int k = 0; k < stored_words; k++)
            begin
                if (op == mas_pkg::OP_ADD)
                    acc = {1'b0, sum_words[k]} - {1'b0, p_words[k]}
                          - {{mas_pkg::WORD_W{1'b0}}, chain};
                else
                    acc = {1'b0, sum_words[k]} + {1'b0, p_words[k]}
                          + {{mas_pkg::WORD_W{1'b0}}, chain};
                sum_words[k] = acc[mas_pkg::WORD_W-1:0];
                chain = acc[mas_pkg::WORD_W];
            end
        end
        for (int k = 0; k < stored_words; k++)
        begin
            beat.word     = sum_words[k];
            beat.index    = mas_pkg::INDEX_W'(k);
            beat.last     = (k == stored_words - 1);
            beat.reduced  = fix;
            beat.too_long = dropped_word;
            expected_words.push_back(beat);
        end
    endfunction

    task automatic absorb_word();
        if (stored_words < mas_pkg::MAX_WORDS)
        begin
            a_words[stored_words] = din.a_word;
            b_words[stored_words] = din.b_word;
            p_words[stored_words] = din.mod_word;
            stored_words++;
        end
        else
        begin
            dropped_word = 1'b1;
        end
        if (din.last_in)
        begin
            compute_reduced_words(din.opcode);
            stored_words = 0;
            dropped_word = 1'b0;
        end
    endtask

    task automatic check_result_beat();
        result_beat_t got;
        result_beat_t want;
        got.word     = dout.result_word;
        got.index    = dout.word_index;
        got.last     = dout.last_out;
        got.reduced  = dout.reduced;
        got.too_long = dout.too_long;
        if (expected_words.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected result beat: word=%h index=%0d last=%b reduced=%b too_long=%b",
                     $time, got.word, got.index, got.last, got.reduced, got.too_long);
        end
        else
        begin
            want = expected_words.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                $display("%0t: expected word=%h index=%0d last=%b reduced=%b too_long=%b",
                         $time, want.word, want.index, want.last, want.reduced, want.too_long);
                $display("%0t: actual   word=%h index=%0d last=%b reduced=%b too_long=%b",
                         $time, got.word, got.index, got.last, got.reduced, got.too_long);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_words = 0;
            dropped_word = 1'b0;
            mismatch_count = 0;
            pending_words <= 0;
        end
        else
        begin
            if (dout.valid && dout.ready)
                check_result_beat();
            if (din.valid && din.ready)
                absorb_word();
            pending_words <= expected_words.size();
        end
    end

endmodule

@@ verif/modular_add_sub_multiword_unit_tb.sv @@
module modular_add_sub_multiword_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_WORDS = 310;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   pending_words;
    int   words_sent = 0;
    logic steady_sender = 1'b0;

    mas_in_if  din ();
    mas_out_if dout ();

    modular_add_sub_multiword_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    mas_result_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .din            (din),
        .dout           (dout),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [mas_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return mas_pkg::WORD_W'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_sender || roll < 65)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    task automatic send_word(input logic op, input logic [mas_pkg::WORD_W-1:0] a,
                             input logic [mas_pkg::WORD_W-1:0] b,
                             input logic [mas_pkg::WORD_W-1:0] p,
                             input logic last);
        int gap;
        din.valid    <= 1'b1;
        din.opcode   <= op;
        din.a_word   <= a;
        din.b_word   <= b;
        din.mod_word <= p;
        din.last_in  <= last;
        do
            @(posedge clk);
        while (!din.ready);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_operand(input int len);
        for (int k = 0; k < len; k++)
            send_word(1'($urandom), pick_word(), pick_word(), pick_word(), k == len - 1);
    endtask

    task automatic wait_for_results();
        din.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words != 0);
    endtask

    initial
    begin
        int roll;
        dout.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                dout.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else if (roll < 90)
            begin
                dout.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                dout.ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int roll;
        int len;
        rst_n        <= 1'b0;
        din.valid    <= 1'b0;
        din.opcode   <= mas_pkg::OP_ADD;
        din.a_word   <= '0;
        din.b_word   <= '0;
        din.mod_word <= '0;
        din.last_in  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single words: carry out, sum equal to p, borrow, and b of all ones
        // without an incoming borrow.
        send_word(mas_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(mas_pkg::OP_ADD, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_word(mas_pkg::OP_SUB, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(mas_pkg::OP_SUB, 16'hFFFF, 16'hFFFF, 16'h1234, 1'b1);
        // Carry rippling into the top word, then a borrow arriving at a b word
        // of all ones.
        send_word(mas_pkg::OP_ADD, 16'hFFFF, 16'h0001, 16'h0000, 1'b0);
        send_word(mas_pkg::OP_ADD, 16'hFFFF, 16'h0000, 16'h8000, 1'b1);
        send_word(mas_pkg::OP_SUB, 16'h0000, 16'h0001, 16'h8000, 1'b0);
        send_word(mas_pkg::OP_SUB, 16'hFFFF, 16'hFFFF, 16'h1234, 1'b1);
        // One word past capacity, the closing beat itself is dropped.
        send_random_operand(mas_pkg::MAX_WORDS + 1);
        wait_for_results();

        while (words_sent < TARGET_WORDS)
        begin
            steady_sender = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 65)
                len = $urandom_range(1, 4);
            else if (roll < 92)
                len = $urandom_range(5, mas_pkg::MAX_WORDS);
            else
                len = $urandom_range(mas_pkg::MAX_WORDS, mas_pkg::MAX_WORDS + 4);
            send_random_operand(len);
            if ($urandom_range(0, 14) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("%0t: timeout, %0d result beats still expected", $time, pending_words);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ modular_add_sub_multiword_unit.f @@
rtl/mas_pkg.sv
rtl/mas_in_if.sv
rtl/mas_out_if.sv
rtl/modular_add_sub_multiword_unit.sv
verif/mas_result_checker.sv
verif/modular_add_sub_multiword_unit_tb.sv
